// File: src/bfd_pkg.sv
// Shared types, constants and helpers for the box filter downscaler.
package bfd_pkg;

    // Geometry limits
    localparam int TARGET_SIZE    = 128;
    localparam int MAX_SOURCE_DIM = 4096;

    localparam int DIM_W   = 13;   // source size register
    localparam int POS_W   = 12;   // source column / row counter
    localparam int BOX_W   = 7;    // output column / row index
    localparam int SIZE_W  = 8;    // output size
    localparam int REM_W   = 8;    // boundary fraction, below the output size
    localparam int SPAN_W  = 7;    // one box side in source pixels
    localparam int CNT_W   = 14;   // pixels in one box
    localparam int SUM_W   = 20;   // per-channel box sum
    localparam int CHAN_W  = 8;
    localparam int DVD_W   = 20;   // dividend of the size divider
    localparam int STEP_W  = 5;    // divider step counter

    localparam int SUMS_W  = 3 * SUM_W;
    localparam int COL_DEPTH = TARGET_SIZE;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;

    localparam logic [DIM_W-1:0] TARGET_DIM = DIM_W'(TARGET_SIZE);
    localparam logic [DIM_W-1:0] MAX_DIM    = DIM_W'(MAX_SOURCE_DIM);

    typedef struct packed {
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
    } pix_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
        logic [BOX_W-1:0]  out_x;
        logic [BOX_W-1:0]  out_y;
        logic [SIZE_W-1:0] thumb_width;
        logic [SIZE_W-1:0] thumb_height;
        logic              last_of_image;
    } res_t;

    // One finished box, handed from the front to the back
    typedef struct packed {
        logic [SUM_W-1:0]  red_sum;
        logic [SUM_W-1:0]  green_sum;
        logic [SUM_W-1:0]  blue_sum;
        logic [CNT_W-1:0]  count;
        logic [BOX_W-1:0]  x;
        logic [BOX_W-1:0]  y;
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic              last;
    } box_t;

    // Size register as used: zero reads as one, large values saturate
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > MAX_DIM)
            r = MAX_DIM;
        return r;
    endfunction

endpackage

// File: src/bfd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module bfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

// File: src/bfd_front.sv
// Front part: size setup, pixel accumulation into column sums, box detection.
module bfd_front import bfd_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic                 push,
    output logic                 full,
    input  pix_t                 pixel,
    output logic                 box_push,
    input  logic                 box_full,
    output box_t                 box_word
);

    typedef enum logic [2:0] {ST_IDLE, ST_RMW, ST_START, ST_SIZE, ST_QW, ST_QH} state_t;

    state_t              state_reg;
    logic [DIM_W-1:0]    src_w_reg, src_h_reg;
    logic [SIZE_W-1:0]   ow_reg, oh_reg;
    logic [DIM_W-1:0]    qw_reg, qh_reg;
    logic [REM_W-1:0]    rw_reg, rh_reg;
    logic [POS_W-1:0]    col_reg, row_reg;
    logic [BOX_W-1:0]    bcol_reg, brow_reg;
    logic [DIM_W-1:0]    cb_reg, cs_reg, rb_reg, rs_reg;
    logic [REM_W-1:0]    cr_reg, rr_reg;
    logic [COL_DEPTH-1:0] valid_reg;
    logic                hit_reg;
    pix_t                pix_reg;
    logic                long_w_reg;
    logic [DVD_W-1:0]    div_quo_reg;
    logic [DIM_W-1:0]    div_rem_reg, div_den_reg;
    logic [STEP_W-1:0]   div_cnt_reg;

    logic [DIM_W-1:0]    sw_e, sh_e;
    logic [DIM_W:0]      div_sh, div_diff;
    logic                div_ge, div_last;
    logic [DIM_W-1:0]    div_rem_new;
    logic [DVD_W-1:0]    div_quo_new;
    logic [SIZE_W-1:0]   short_side;

    logic [SUMS_W-1:0]   ram_q;
    logic                ram_re, ram_we;
    logic [SUM_W-1:0]    sum_r, sum_g, sum_b;
    logic                last_col, last_row, emit, advance;
    logic [DIM_W-1:0]    col_inc, row_inc;
    logic [DIM_W-1:0]    cb_adv, rb_adv;
    logic [REM_W-1:0]    cr_adv, rr_adv;
    logic [SPAN_W-1:0]   span_w, span_h;

    assign sw_e = eff_dim(src_w_reg);
    assign sh_e = eff_dim(src_h_reg);

    // Handshakes: configuration wins over a pixel in the same cycle
    assign cfg_ready = (state_reg == ST_IDLE);
    assign full      = (state_reg != ST_IDLE) || cfg_valid;

    // One restoring division step for the size setup
    always_comb
    begin
        div_sh      = {div_rem_reg, div_quo_reg[DVD_W-1]};
        div_diff    = div_sh - {1'b0, div_den_reg};
        div_ge      = (div_sh >= {1'b0, div_den_reg});
        div_rem_new = div_ge ? div_diff[DIM_W-1:0] : div_sh[DIM_W-1:0];
        div_quo_new = {div_quo_reg[DVD_W-2:0], div_ge};
        div_last    = (div_cnt_reg == STEP_W'(DVD_W - 1));
        short_side  = (div_quo_new == '0) ? SIZE_W'(1) : div_quo_new[SIZE_W-1:0];
    end

    // Column sum storage
    bfd_ram #(.WIDTH(SUMS_W), .DEPTH(COL_DEPTH)) u_sums (
        .clk   (clk),
        .we    (ram_we),
        .waddr (bcol_reg),
        .wdata ({sum_r, sum_g, sum_b}),
        .re    (ram_re),
        .raddr (bcol_reg),
        .rdata (ram_q)
    );

    assign ram_re = (state_reg == ST_IDLE) && push && !full;

    // Read-modify-write of the current column and boundary tests
    always_comb
    begin
        sum_r    = (hit_reg ? ram_q[3*SUM_W-1:2*SUM_W] : '0) + SUM_W'(pix_reg.red_in);
        sum_g    = (hit_reg ? ram_q[2*SUM_W-1:SUM_W] : '0) + SUM_W'(pix_reg.green_in);
        sum_b    = (hit_reg ? ram_q[SUM_W-1:0] : '0) + SUM_W'(pix_reg.blue_in);
        col_inc  = {1'b0, col_reg} + DIM_W'(1);
        row_inc  = {1'b0, row_reg} + DIM_W'(1);
        last_col = (col_inc == cb_reg);
        last_row = (row_inc == rb_reg);
        emit     = last_col && last_row;
        advance  = (state_reg == ST_RMW) && !(emit && box_full);
        ram_we   = advance;
        box_push = advance && emit;
        span_w   = SPAN_W'(cb_reg - cs_reg);
        span_h   = SPAN_W'(rb_reg - rs_reg);
        // next box boundaries: add quotient, carry the fraction
        if ({1'b0, cr_reg} + {1'b0, rw_reg} >= {1'b0, ow_reg})
        begin
            cr_adv = REM_W'({1'b0, cr_reg} + {1'b0, rw_reg} - {1'b0, ow_reg});
            cb_adv = cb_reg + qw_reg + DIM_W'(1);
        end
        else
        begin
            cr_adv = cr_reg + rw_reg;
            cb_adv = cb_reg + qw_reg;
        end
        if ({1'b0, rr_reg} + {1'b0, rh_reg} >= {1'b0, oh_reg})
        begin
            rr_adv = REM_W'({1'b0, rr_reg} + {1'b0, rh_reg} - {1'b0, oh_reg});
            rb_adv = rb_reg + qh_reg + DIM_W'(1);
        end
        else
        begin
            rr_adv = rr_reg + rh_reg;
            rb_adv = rb_reg + qh_reg;
        end
    end

    always_comb
    begin
        box_word.red_sum   = sum_r;
        box_word.green_sum = sum_g;
        box_word.blue_sum  = sum_b;
        box_word.count     = CNT_W'(span_w) * CNT_W'(span_h);
        box_word.x         = bcol_reg;
        box_word.y         = brow_reg;
        box_word.width     = ow_reg;
        box_word.height    = oh_reg;
        box_word.last      = ({1'b0, bcol_reg} + SIZE_W'(1) == ow_reg) &&
                             ({1'b0, brow_reg} + SIZE_W'(1) == oh_reg);
    end

    // State machine, positions and size setup
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            src_w_reg   <= DIM_W'(1);
            src_h_reg   <= DIM_W'(1);
            ow_reg      <= SIZE_W'(1);
            oh_reg      <= SIZE_W'(1);
            qw_reg      <= DIM_W'(1);
            qh_reg      <= DIM_W'(1);
            rw_reg      <= '0;
            rh_reg      <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            bcol_reg    <= '0;
            brow_reg    <= '0;
            cb_reg      <= DIM_W'(1);
            cs_reg      <= '0;
            cr_reg      <= '0;
            rb_reg      <= DIM_W'(1);
            rs_reg      <= '0;
            rr_reg      <= '0;
            valid_reg   <= '0;
            hit_reg     <= 1'b0;
            pix_reg     <= '0;
            long_w_reg  <= 1'b0;
            div_quo_reg <= '0;
            div_rem_reg <= '0;
            div_den_reg <= DIM_W'(1);
            div_cnt_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        if (cfg_index == REG_SOURCE_WIDTH)
                        begin
                            src_w_reg <= cfg_data;
                            state_reg <= ST_START;
                        end
                        else if (cfg_index == REG_SOURCE_HEIGHT)
                        begin
                            src_h_reg <= cfg_data;
                            state_reg <= ST_START;
                        end
                    end
                    else if (push)
                    begin
                        pix_reg   <= pixel;
                        hit_reg   <= valid_reg[bcol_reg];
                        state_reg <= ST_RMW;
                    end
                end

                ST_RMW:
                begin
                    if (advance)
                    begin
                        state_reg           <= ST_IDLE;
                        valid_reg[bcol_reg] <= 1'b1;
                        col_reg             <= col_inc[POS_W-1:0];
                        if (last_col)
                        begin
                            bcol_reg <= bcol_reg + BOX_W'(1);
                            cs_reg   <= cb_reg;
                            cb_reg   <= cb_adv;
                            cr_reg   <= cr_adv;
                        end
                        // end of a source row
                        if (col_inc >= sw_e)
                        begin
                            col_reg  <= '0;
                            bcol_reg <= '0;
                            cs_reg   <= '0;
                            cb_reg   <= qw_reg;
                            cr_reg   <= rw_reg;
                            row_reg  <= row_inc[POS_W-1:0];
                            if (row_inc >= rb_reg)
                            begin
                                valid_reg <= '0;
                                brow_reg  <= brow_reg + BOX_W'(1);
                                rs_reg    <= rb_reg;
                                rb_reg    <= rb_adv;
                                rr_reg    <= rr_adv;
                            end
                            if (row_inc >= sh_e)
                            begin
                                row_reg  <= '0;
                                brow_reg <= '0;
                                rs_reg   <= '0;
                                rb_reg   <= qh_reg;
                                rr_reg   <= rh_reg;
                            end
                        end
                    end
                end

                ST_START:
                begin
                    col_reg     <= '0;
                    row_reg     <= '0;
                    bcol_reg    <= '0;
                    brow_reg    <= '0;
                    cs_reg      <= '0;
                    rs_reg      <= '0;
                    cr_reg      <= '0;
                    rr_reg      <= '0;
                    valid_reg   <= '0;
                    div_rem_reg <= '0;
                    div_cnt_reg <= '0;
                    if (sw_e <= TARGET_DIM && sh_e <= TARGET_DIM)
                    begin
                        // already fits: one source pixel per box
                        ow_reg    <= sw_e[SIZE_W-1:0];
                        oh_reg    <= sh_e[SIZE_W-1:0];
                        qw_reg    <= DIM_W'(1);
                        qh_reg    <= DIM_W'(1);
                        rw_reg    <= '0;
                        rh_reg    <= '0;
                        cb_reg    <= DIM_W'(1);
                        rb_reg    <= DIM_W'(1);
                        state_reg <= ST_IDLE;
                    end
                    else if (sw_e >= sh_e)
                    begin
                        long_w_reg  <= 1'b1;
                        ow_reg      <= SIZE_W'(TARGET_SIZE);
                        div_quo_reg <= DVD_W'(sh_e) * DVD_W'(TARGET_SIZE);
                        div_den_reg <= sw_e;
                        state_reg   <= ST_SIZE;
                    end
                    else
                    begin
                        long_w_reg  <= 1'b0;
                        oh_reg      <= SIZE_W'(TARGET_SIZE);
                        div_quo_reg <= DVD_W'(sw_e) * DVD_W'(TARGET_SIZE);
                        div_den_reg <= sh_e;
                        state_reg   <= ST_SIZE;
                    end
                end

                ST_SIZE, ST_QW, ST_QH:
                begin
                    div_quo_reg <= div_quo_new;
                    div_rem_reg <= div_rem_new;
                    div_cnt_reg <= div_cnt_reg + STEP_W'(1);
                    if (div_last)
                    begin
                        div_rem_reg <= '0;
                        div_cnt_reg <= '0;
                        if (state_reg == ST_SIZE)
                        begin
                            // short side known; next: source width per box
                            div_quo_reg <= DVD_W'(sw_e);
                            if (long_w_reg)
                            begin
                                oh_reg      <= short_side;
                                div_den_reg <= DIM_W'(ow_reg);
                            end
                            else
                            begin
                                ow_reg      <= short_side;
                                div_den_reg <= DIM_W'(short_side);
                            end
                            state_reg <= ST_QW;
                        end
                        else if (state_reg == ST_QW)
                        begin
                            qw_reg      <= div_quo_new[DIM_W-1:0];
                            rw_reg      <= div_rem_new[REM_W-1:0];
                            div_quo_reg <= DVD_W'(sh_e);
                            div_den_reg <= DIM_W'(oh_reg);
                            state_reg   <= ST_QH;
                        end
                        else
                        begin
                            qh_reg    <= div_quo_new[DIM_W-1:0];
                            rh_reg    <= div_rem_new[REM_W-1:0];
                            cb_reg    <= qw_reg;
                            cr_reg    <= rw_reg;
                            rb_reg    <= div_quo_new[DIM_W-1:0];
                            rr_reg    <= div_rem_new[REM_W-1:0];
                            state_reg <= ST_IDLE;
                        end
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: src/bfd_queue.sv
// Short queue of finished boxes between the front and the back.
module bfd_queue import bfd_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    output logic full,
    input  box_t wdata,
    input  logic rd,
    output logic empty,
    output box_t rdata
);

    box_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, rptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_wr, do_rd;

    assign full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = mem[rptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wptr_reg] <= wdata;
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wptr_reg <= wptr_reg + QPTR_W'(1);
            if (do_rd)
                rptr_reg <= rptr_reg + QPTR_W'(1);
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + QCNT_W'(1);
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - QCNT_W'(1);
        end
    end

endmodule

// File: src/bfd_back.sv
// Back part: divides each finished box's sums by its pixel count, holds the result.
module bfd_back import bfd_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic q_empty,
    output logic q_pop,
    input  box_t q_word,
    output logic empty,
    input  logic pop,
    output res_t result
);

    logic              busy_reg, done_reg, out_valid_reg;
    logic [STEP_W-1:0] step_reg;
    logic [SUM_W-1:0]  quo_reg [3];
    logic [CNT_W-1:0]  rem_reg [3];
    box_t              meta_reg;
    res_t              out_reg;

    logic [CNT_W:0]    sh   [3];
    logic              ge   [3];
    logic [SUM_W-1:0]  quo_new [3];
    logic [CNT_W-1:0]  rem_new [3];
    logic              load_out;

    assign q_pop    = !busy_reg && !q_empty;
    assign empty    = !out_valid_reg;
    assign result   = out_reg;
    assign load_out = busy_reg && done_reg && (!out_valid_reg || pop);

    // One restoring step per channel
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sh[c]      = {rem_reg[c], quo_reg[c][SUM_W-1]};
            ge[c]      = (sh[c] >= {1'b0, meta_reg.count});
            rem_new[c] = ge[c] ? CNT_W'(sh[c] - {1'b0, meta_reg.count}) : sh[c][CNT_W-1:0];
            quo_new[c] = {quo_reg[c][SUM_W-2:0], ge[c]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            meta_reg      <= '0;
            out_reg       <= '0;
            for (int c = 0; c < 3; c++)
            begin
                quo_reg[c] <= '0;
                rem_reg[c] <= '0;
            end
        end
        else
        begin
            // take a new box word
            if (q_pop)
            begin
                busy_reg   <= 1'b1;
                done_reg   <= 1'b0;
                step_reg   <= '0;
                meta_reg   <= q_word;
                quo_reg[0] <= q_word.red_sum;
                quo_reg[1] <= q_word.green_sum;
                quo_reg[2] <= q_word.blue_sum;
                for (int c = 0; c < 3; c++)
                    rem_reg[c] <= '0;
            end
            else if (busy_reg && !done_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                for (int c = 0; c < 3; c++)
                begin
                    quo_reg[c] <= quo_new[c];
                    rem_reg[c] <= rem_new[c];
                end
                if (step_reg == STEP_W'(SUM_W - 1))
                    done_reg <= 1'b1;
            end

            // output register
            if (load_out)
            begin
                busy_reg              <= 1'b0;
                out_valid_reg         <= 1'b1;
                out_reg.red_out       <= quo_reg[0][CHAN_W-1:0];
                out_reg.green_out     <= quo_reg[1][CHAN_W-1:0];
                out_reg.blue_out      <= quo_reg[2][CHAN_W-1:0];
                out_reg.out_x         <= meta_reg.x;
                out_reg.out_y         <= meta_reg.y;
                out_reg.thumb_width   <= meta_reg.width;
                out_reg.thumb_height  <= meta_reg.height;
                out_reg.last_of_image <= meta_reg.last;
            end
            else if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: src/box_filter_downscaler.sv
// Top level of the box filter downscaler: front, box queue, divider back end.
//
//  channel   handshake              payload
//  pixels    push / full            pixel (pix_t)
//  results   empty / pop            result (res_t)
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  In the front each pixel gets a column-sum RAM read, then an update.
//  In the back each finished box is taken from the queue, put through a
//  20-step restoring divide of the three sums, then loaded into the output;
//  a 4-word queue sits between them.
//  A size write recomputes the output size, with a serial divider unless
//  the image fits; meanwhile cfg_ready is low and full is high.
//  Reset leaves a 1x1 source; the sums need no clearing pass (per-column
//  valid bits). full is also high while a box waits for queue room.
module box_filter_downscaler import bfd_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  pix_t                 pixel,
    output logic                 empty,
    input  logic                 pop,
    output res_t                 result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    logic box_push, box_full, q_empty, q_pop;
    box_t box_word, q_word;

    bfd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .pixel     (pixel),
        .box_push  (box_push),
        .box_full  (box_full),
        .box_word  (box_word)
    );

    bfd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (box_push),
        .full  (box_full),
        .wdata (box_word),
        .rd    (q_pop),
        .empty (q_empty),
        .rdata (q_word)
    );

    bfd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .q_word  (q_word),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

// File: src/bfd_checker.sv
// Port-level checks for the box filter downscaler, bound to the top level.
module bfd_checker import bfd_pkg::*; (
    input logic clk,
    input logic rst_n,
    input logic push,
    input logic full,
    input logic empty,
    input logic pop,
    input res_t result,
    input logic cfg_ready
);

    // Busy with a size update means no pixel is taken
    a_cfg_busy_full: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_ready |-> full)
        else $error("pixel port open while size setup runs");

    // A taken pixel makes full rise, so pixels are not taken back to back
    a_pixel_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> full)
        else $error("front took pixels back to back");

    // Coordinates stay inside the thumbnail
    a_coord_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ({1'b0, result.out_x} < result.thumb_width) &&
                   ({1'b0, result.out_y} < result.thumb_height))
        else $error("result coordinates outside thumbnail");

    // Last-of-image flag only on the bottom right box
    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.last_of_image) |->
            ({1'b0, result.out_x} + SIZE_W'(1) == result.thumb_width) &&
            ({1'b0, result.out_y} + SIZE_W'(1) == result.thumb_height))
        else $error("last flag away from last box");

    // A waiting result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty && $stable(result))
        else $error("result word changed while waiting");

endmodule

bind box_filter_downscaler bfd_checker u_bfd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_ready (cfg_ready)
);
